// ===== src/sprblt_pkg.sv =====
// shared constants for the sprite blitter: default memory depths, parameter slots
// and control / bank register bit positions
// no dependencies
package sprblt_pkg;

    localparam int unsigned VIDEO_DEPTH_DEF  = 32768;
    localparam int unsigned SPRITE_DEPTH_DEF = 524288;

    // blit parameter slots
    localparam logic [2:0] P_VX      = 3'd0;
    localparam logic [2:0] P_VY      = 3'd1;
    localparam logic [2:0] P_GX      = 3'd2;
    localparam logic [2:0] P_GY      = 3'd3;
    localparam logic [2:0] P_WIDTH   = 3'd4;
    localparam logic [2:0] P_HEIGHT  = 3'd5;
    localparam logic [2:0] P_TRIGGER = 3'd6;
    localparam logic [2:0] P_COLOUR  = 3'd7;

    // configuration register indexes
    localparam logic CFG_CONTROL = 1'b0;
    localparam logic CFG_BANK    = 1'b1;

    // control_mode bits
    localparam int CM_COPY   = 0;
    localparam int CM_FILL   = 3;
    localparam int CM_CARRY  = 4;
    localparam int CM_VIDEO  = 5;
    localparam int CM_IRQ    = 6;
    localparam int CM_OPAQUE = 7;

    // bank_select bits
    localparam int BS_PAGE  = 3;
    localparam int BS_CLIPX = 4;
    localparam int BS_CLIPY = 5;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // source coordinate step: full carry or low nibble wrap
    function automatic logic [7:0] src_step(input logic [7:0] g, input logic carry);
        logic [7:0] inc;
        begin
            inc = g + 8'd1;
            src_step = carry ? inc : {g[7:4], inc[3:0]};
        end
    endfunction

endpackage

// ===== src/sprite_blitter_with_vram_window_unit.sv =====
// sprite blitter behind a 16K bus window, with video and sprite memories
// depends on sprblt_pkg
//
// channel   direction  signals
// access    in         start, command, address, data (busy is out)
// result    out        done, read_data, float_read, irq_clear, irq_schedule, irq_delay
// config    in         cfg_we, cfg_index, cfg_data
//
// a direct write or parameter write ends its beat on acceptance, a read passes through S_RDATA (registered memory read)
// a blit reads the sprite (S_PIX_RD) then writes video (S_PIX_WR) for each pixel, walking
// width by height with the x and y step counters, and then ends in S_FINISH
// busy is high after acceptance of a read or blit until the result beat, done pulses for one cycle
// reset clears control state and parameters; memories are undefined until written
// the receiver cannot stall: each result is shown for exactly one cycle
module sprite_blitter_with_vram_window_unit
    import sprblt_pkg::*;
#(
    parameter int unsigned VIDEO_DEPTH  = VIDEO_DEPTH_DEF,
    parameter int unsigned SPRITE_DEPTH = SPRITE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [13:0] address,
    input  logic [7:0]  data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        done,
    output logic [7:0]  read_data,
    output logic        float_read,
    output logic        irq_clear,
    output logic        irq_schedule,
    output logic [13:0] irq_delay
);

    localparam int VA_W = $clog2(VIDEO_DEPTH);
    localparam int SA_W = $clog2(SPRITE_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDATA  = 3'd1;
    localparam logic [2:0] S_PIX_RD = 3'd2;
    localparam logic [2:0] S_PIX_WR = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [7:0]  control_reg, bank_reg;
    logic [7:0]  params_reg [8];
    logic [1:0]  quad_reg;
    logic [6:0]  xcnt_reg, ycnt_reg;
    logic [7:0]  vx_reg, vy_reg, gx_reg, gy_reg;
    logic        rd_video_reg;

    logic        done_reg;
    logic [7:0]  read_data_reg;
    logic        float_read_reg, irq_clear_reg, irq_schedule_reg;
    logic [13:0] irq_delay_reg;

    logic [7:0]  video_mem [VIDEO_DEPTH];
    logic [7:0]  sprite_mem [SPRITE_DEPTH];
    logic [7:0]  video_q, sprite_q;

    logic        accept;
    logic        copy_mode;
    logic [6:0]  width, height;
    logic [7:0]  sx, sy;
    logic [18:0] src_full, direct_full;
    logic [14:0] vid_direct_full, vid_blit_full;
    logic [SA_W-1:0] spr_raddr;
    logic        spr_we, vid_we;
    logic [VA_W-1:0] vid_waddr;
    logic [7:0]  vid_wdata, pix;
    logic        pix_write;
    logic        last_x, last_y;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign copy_mode = control_reg[CM_COPY];
    assign width     = params_reg[P_WIDTH][6:0];
    assign height    = params_reg[P_HEIGHT][6:0];

    assign sx = params_reg[P_WIDTH][7]  ? ~gx_reg : gx_reg;
    assign sy = params_reg[P_HEIGHT][7] ? ~gy_reg : gy_reg;
    assign src_full    = {bank_reg[2:0], sy[7], sx[7], sy[6:0], sx[6:0]};
    assign direct_full = {bank_reg[2:0], quad_reg, address};
    assign vid_direct_full = {bank_reg[BS_PAGE], address};
    assign vid_blit_full   = {bank_reg[BS_PAGE], vy_reg[6:0], vx_reg[6:0]};

    assign spr_raddr = (state_reg == S_IDLE) ? direct_full[SA_W-1:0] : src_full[SA_W-1:0];
    assign spr_we    = accept && !copy_mode && !control_reg[CM_VIDEO] && command == CMD_WRITE;

    assign pix = control_reg[CM_FILL] ? ~params_reg[P_COLOUR] : sprite_q;
    assign pix_write = (control_reg[CM_OPAQUE] || pix != 8'd0)
                       && !(vx_reg[7] && bank_reg[BS_CLIPX])
                       && !(vy_reg[7] && bank_reg[BS_CLIPY]);
    assign last_x = (xcnt_reg == width - 7'd1);
    assign last_y = (ycnt_reg == height - 7'd1);

    always_comb
    begin
        vid_we    = 1'b0;
        vid_waddr = vid_direct_full[VA_W-1:0];
        vid_wdata = data;
        if (state_reg == S_PIX_WR)
        begin
            vid_we    = pix_write;
            vid_waddr = vid_blit_full[VA_W-1:0];
            vid_wdata = pix;
        end
        else if (accept && !copy_mode && control_reg[CM_VIDEO] && command == CMD_WRITE)
        begin
            vid_we = 1'b1;
        end
    end

    // memories: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (vid_we)
        begin
            video_mem[vid_waddr] <= vid_wdata;
        end
        video_q <= video_mem[vid_direct_full[VA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (spr_we)
        begin
            sprite_mem[direct_full[SA_W-1:0]] <= data;
        end
        sprite_q <= sprite_mem[spr_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (copy_mode && command == CMD_WRITE && address[3:0] == {1'b0, P_TRIGGER}
                        && data[0])
                    begin
                        state_next = (width == 7'd0 || height == 7'd0) ? S_FINISH : S_PIX_RD;
                    end
                    else if (!copy_mode && command == CMD_READ)
                    begin
                        state_next = S_RDATA;
                    end
                end
            end
            S_RDATA:  state_next = S_IDLE;
            S_PIX_RD: state_next = S_PIX_WR;
            S_PIX_WR: state_next = (last_x && last_y) ? S_FINISH : S_PIX_RD;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            control_reg      <= 8'd0;
            bank_reg         <= 8'd0;
            quad_reg         <= 2'd0;
            done_reg         <= 1'b0;
            rd_video_reg     <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                params_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CONTROL: control_reg <= cfg_data;
                    CFG_BANK:    bank_reg    <= cfg_data;
                    default:     control_reg <= cfg_data;
                endcase
            end
            if (accept && copy_mode && command == CMD_WRITE && address[3] == 1'b0
                && address[2:0] != P_TRIGGER)
            begin
                params_reg[address[2:0]] <= data;
            end
            if (accept)
            begin
                rd_video_reg <= control_reg[CM_VIDEO];
                // beat finishes here unless a read or a blit follows
                done_reg <= (state_next == S_IDLE);
            end
            if (state_reg == S_PIX_RD)
            begin
                quad_reg <= {sy[7], sx[7]};
            end
            if (state_reg == S_RDATA || state_reg == S_FINISH)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // blit walk counters and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xcnt_reg         <= 7'd0;
            ycnt_reg         <= 7'd0;
            vx_reg           <= {1'b0, params_reg[P_VX][6:0]};
            vy_reg           <= {1'b0, params_reg[P_VY][6:0]};
            gx_reg           <= params_reg[P_GX];
            gy_reg           <= params_reg[P_GY];
            read_data_reg    <= 8'd0;
            float_read_reg   <= copy_mode && command == CMD_READ;
            irq_clear_reg    <= copy_mode && command == CMD_WRITE
                                && address[3:0] == {1'b0, P_TRIGGER} && !data[0];
            irq_schedule_reg <= 1'b0;
            irq_delay_reg    <= 14'd0;
        end
        else if (state_reg == S_PIX_WR)
        begin
            if (last_x)
            begin
                xcnt_reg <= 7'd0;
                ycnt_reg <= ycnt_reg + 7'd1;
                vx_reg   <= {1'b0, params_reg[P_VX][6:0]};
                gx_reg   <= params_reg[P_GX];
                vy_reg   <= vy_reg + 8'd1;
                gy_reg   <= src_step(gy_reg, control_reg[CM_CARRY]);
            end
            else
            begin
                xcnt_reg <= xcnt_reg + 7'd1;
                vx_reg   <= vx_reg + 8'd1;
                gx_reg   <= src_step(gx_reg, control_reg[CM_CARRY]);
            end
        end
        else if (state_reg == S_RDATA)
        begin
            read_data_reg <= rd_video_reg ? video_q : sprite_q;
        end
        else if (state_reg == S_FINISH)
        begin
            irq_clear_reg    <= control_reg[CM_IRQ];
            irq_schedule_reg <= control_reg[CM_IRQ];
            irq_delay_reg    <= control_reg[CM_IRQ] ? {7'd0, width} * {7'd0, height} : 14'd0;
        end
    end

    assign done         = done_reg;
    assign read_data    = read_data_reg;
    assign float_read   = float_read_reg;
    assign irq_clear    = irq_clear_reg;
    assign irq_schedule = irq_schedule_reg;
    assign irq_delay    = irq_delay_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_sched_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done && irq_schedule |-> irq_clear)
        else $error("irq scheduled without clear");

    a_float_read: assert property (@(posedge clk) disable iff (!rst_n)
        done && float_read |-> read_data == 8'd0 && !irq_clear)
        else $error("floating read beat carries data");

    a_pix_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PIX_RD |=> state_reg == S_PIX_WR)
        else $error("pixel read not followed by write");

endmodule
